// ===== rtl/b2da_pkg.sv =====
`default_nettype none

package b2da_pkg;

   // input and result widths
   localparam int NUMBER_W = 32;
   localparam int CHAR_W   = 6;

   // a 32-bit value never needs more than ten decimal digits
   localparam int DIGIT_LIMIT = 10;
   localparam int MAX_DIGITS  = 10;
   localparam int DIGIT_CAP   = (MAX_DIGITS > DIGIT_LIMIT) ? DIGIT_LIMIT :
                                ((MAX_DIGITS < 1) ? 1 : MAX_DIGITS);

   localparam int CNT_W = $clog2(DIGIT_LIMIT + 1);
   localparam int IDX_W = $clog2(DIGIT_LIMIT);
   localparam int BCD_W = 4 * DIGIT_LIMIT;

   // shift-and-add-3 converter, two bits per cycle
   localparam int BITS_PER_STEP = 2;
   localparam int STEPS         = NUMBER_W / BITS_PER_STEP;
   localparam int STEP_W        = $clog2(STEPS);

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);
   localparam logic [3:0]        DIGIT_NINE = 4'd9;

   // decimal thresholds: a value at or above POW10[k] has more than k digits
   localparam logic [NUMBER_W-1:0] POW10 [1:DIGIT_LIMIT-1] = '{
      32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000,
      32'd1000000, 32'd10000000, 32'd100000000, 32'd1000000000
   };

   // one classified transaction waiting for the converter
   typedef struct packed {
      logic [NUMBER_W-1:0] number;
      logic [CNT_W-1:0]    count;
      logic                sat;
   } queue_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

`default_nettype wire

// ===== rtl/b2da_req_if.sv =====
`default_nettype none

interface b2da_req_if;
   logic                          valid;
   logic                          ready;
   logic [b2da_pkg::NUMBER_W-1:0] number;

   modport source (output valid, output number, input ready);
   modport sink   (input valid, input number, output ready);
endinterface

`default_nettype wire

// ===== rtl/b2da_rsp_if.sv =====
`default_nettype none

interface b2da_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [b2da_pkg::CHAR_W-1:0] digit_char;
   logic                        last;

   modport source (output valid, output digit_char, output last, input ready);
   modport sink   (input valid, input digit_char, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/binary_to_decimal_ascii.sv =====
`default_nettype none

// Converts one unsigned 32-bit number per req transaction into its decimal
// text, one rsp transaction per ASCII digit, most significant first, no
// leading zeros (zero gives a single '0'), with last set on the final digit.
// A front stage counts the digits and hands the number to a two-entry queue,
// so req is accepted while a conversion or its output is still under way.
// The back end converts with a shift-and-add-3 unit that takes two bits per
// cycle, then emits one digit per cycle that rsp takes.

module binary_to_decimal_ascii (
   input  logic        clock,
   input  logic        reset,
   b2da_req_if.sink    req,
   b2da_rsp_if.source  rsp
);
   import b2da_pkg::*;

   logic              push;
   logic              pop;
   queue_entry_type   push_entry;
   queue_entry_type   pop_entry;
   queue_status_type  q_status;

   // classify and accept
   b2da_front u_front (
      .req        (req),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry)
   );

   // decoupling queue
   b2da_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .q_status   (q_status)
   );

   // convert and emit
   b2da_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_status.empty),
      .pop_entry (pop_entry),
      .pop       (pop),
      .rsp       (rsp)
   );

   // queue never overflows or underflows
   assert property (@(posedge clock) disable iff (reset) push |-> !q_status.full)
      else $error("queue push while full");
   assert property (@(posedge clock) disable iff (reset) pop |-> !q_status.empty)
      else $error("queue pop while empty");

   // queued counts stay within the digit cap
   assert property (@(posedge clock) disable iff (reset)
      push |-> (push_entry.count != '0 && push_entry.count <= CNT_W'(DIGIT_CAP)))
      else $error("bad digit count queued");

   // every emitted character is a decimal digit
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.digit_char >= CHAR_W'(48) && rsp.digit_char <= CHAR_W'(57)))
      else $error("non-digit character emitted");

endmodule

`default_nettype wire

// ===== rtl/b2da_front.sv =====
`default_nettype none

module b2da_front (
   b2da_req_if.sink                    req,
   input  b2da_pkg::queue_status_type  q_status,
   output logic                        push,
   output b2da_pkg::queue_entry_type   push_entry
);
   import b2da_pkg::*;

   logic [CNT_W-1:0] ndig;

   // count significant digits against the decimal thresholds
   always_comb begin
      ndig = CNT_W'(1);
      for (int k = 1; k < DIGIT_LIMIT; k++) begin
         if (req.number >= POW10[k]) begin
            ndig = ndig + CNT_W'(1);
         end
      end
   end

   // accept while the queue has room
   assign req.ready = !q_status.full;
   assign push      = req.valid && !q_status.full;

   // saturate runs that need more digits than allowed
   always_comb begin
      push_entry.number = req.number;
      if (ndig > CNT_W'(DIGIT_CAP)) begin
         push_entry.count = CNT_W'(DIGIT_CAP);
         push_entry.sat   = 1'b1;
      end else begin
         push_entry.count = ndig;
         push_entry.sat   = 1'b0;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/b2da_queue.sv =====
`default_nettype none

module b2da_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  b2da_pkg::queue_entry_type   push_entry,
   input  logic                        pop,
   output b2da_pkg::queue_entry_type   pop_entry,
   output b2da_pkg::queue_status_type  q_status
);
   import b2da_pkg::*;

   queue_entry_type     slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   fill_ff, fill_in;

   // pointer wrap
   function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
      if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + QPTR_W'(1);
   endfunction

   assign q_status.full  = (fill_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_status.empty = (fill_ff == '0);
   assign pop_entry      = slot_ff[rd_ptr_ff];

   // pointer and fill update
   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/b2da_back.sv =====
`default_nettype none

module b2da_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_empty,
   input  b2da_pkg::queue_entry_type   pop_entry,
   output logic                        pop,
   b2da_rsp_if.source                  rsp
);
   import b2da_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_CONV = 3'b010,
      S_EMIT = 3'b100
   } state_type;

   state_type             state_ff, state_in;
   logic [BCD_W-1:0]      bcd_ff, bcd_in;
   logic [NUMBER_W-1:0]   bin_ff, bin_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic                  sat_ff, sat_in;
   logic [3:0]            digit;
   logic                  done_tx;

   // one shift-and-add-3 step over the joined bcd and binary word
   function automatic logic [BCD_W+NUMBER_W-1:0] dd_step(
      input logic [BCD_W+NUMBER_W-1:0] v
   );
      logic [BCD_W+NUMBER_W-1:0] t;
      t = v;
      for (int i = 0; i < DIGIT_LIMIT; i++) begin
         if (t[NUMBER_W + 4*i +: 4] >= 4'd5) begin
            t[NUMBER_W + 4*i +: 4] = t[NUMBER_W + 4*i +: 4] + 4'd3;
         end
      end
      return {t[BCD_W+NUMBER_W-2:0], 1'b0};
   endfunction

   // digit under the emit index, most significant first
   always_comb begin
      if (sat_ff) begin
         digit = DIGIT_NINE;
      end else begin
         digit = bcd_ff[{idx_ff, 2'b00} +: 4];
      end
   end

   assign rsp.valid      = (state_ff == S_EMIT);
   assign rsp.digit_char = ASCII_ZERO + CHAR_W'(digit);
   assign rsp.last       = (idx_ff == '0);

   assign done_tx = rsp.valid && rsp.ready && rsp.last;
   assign pop     = !q_empty && ((state_ff == S_IDLE) || done_tx);

   // sequencer: load, convert, emit
   always_comb begin
      logic [BCD_W+NUMBER_W-1:0] w;
      state_in = state_ff;
      bcd_in   = bcd_ff;
      bin_in   = bin_ff;
      step_in  = step_ff;
      idx_in   = idx_ff;
      sat_in   = sat_ff;
      w        = {bcd_ff, bin_ff};
      case (state_ff)
         S_IDLE: begin
            if (pop) begin
               state_in = S_CONV;
            end
         end
         S_CONV: begin
            for (int s = 0; s < BITS_PER_STEP; s++) begin
               w = dd_step(w);
            end
            bcd_in  = w[BCD_W+NUMBER_W-1:NUMBER_W];
            bin_in  = w[NUMBER_W-1:0];
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(STEPS - 1)) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (rsp.valid && rsp.ready) begin
               if (rsp.last) begin
                  state_in = pop ? S_CONV : S_IDLE;
               end else begin
                  idx_in = idx_ff - IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      // load a fresh transaction from the queue
      if (pop) begin
         bcd_in  = '0;
         bin_in  = pop_entry.number;
         step_in = '0;
         idx_in  = IDX_W'(pop_entry.count - CNT_W'(1));
         sat_in  = pop_entry.sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      bcd_ff  <= bcd_in;
      bin_ff  <= bin_in;
      step_ff <= step_in;
      idx_ff  <= idx_in;
      sat_ff  <= sat_in;
   end

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import b2da_pkg::*;

   localparam int RANDOM_PER_PHASE = 88;
   localparam int DRAIN_CYCLES     = 40;
   localparam int CYCLE_LIMIT      = 300000;

   // values at several digit count edges and the bit patterns at both ends
   localparam logic [NUMBER_W-1:0] DIRECTED_NUMBERS [0:17] = '{
      32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd12345,
      32'd999999, 32'd1000000, 32'd999999999, 32'd1000000000,
      32'd1000000009, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA,
      32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'd4000000000
   };

   typedef struct packed {
      logic [CHAR_W-1:0] digit_char;
      logic              last;
   } digit_entry_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   b2da_req_if req_ch ();
   b2da_rsp_if rsp_ch ();

   binary_to_decimal_ascii u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   logic [NUMBER_W-1:0] pending_numbers [$];
   digit_entry_type     expected_digits [$];
   int                  req_idle_pct  = 0;
   int                  rsp_stall_pct = 0;
   int                  error_count   = 0;
   int                  cycle_count   = 0;

   // clock generation
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // decimal digits of one number, most significant first, pushed as expectations
   function automatic void predict_digits(input logic [NUMBER_W-1:0] value);
      logic [3:0]          low_first [DIGIT_LIMIT];
      logic [NUMBER_W-1:0] rest;
      int                  count;
      digit_entry_type     entry;
      rest         = value;
      low_first[0] = 4'(rest % 10);
      rest         = rest / 10;
      count        = 1;
      while (rest != 0 && count < DIGIT_LIMIT) begin
         low_first[count] = 4'(rest % 10);
         rest             = rest / 10;
         count++;
      end
      // a run longer than the cap saturates to all nines
      if (count > DIGIT_CAP) begin
         for (int k = 0; k < DIGIT_CAP; k++) low_first[k] = DIGIT_NINE;
         count = DIGIT_CAP;
      end
      for (int k = 0; k < count; k++) begin
         entry.digit_char = CHAR_W'(ASCII_ZERO + CHAR_W'(low_first[count - 1 - k]));
         entry.last       = (k == count - 1);
         expected_digits.push_back(entry);
      end
   endfunction

   // driver: predict on each accepted transaction, then offer the next number
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid  <= 1'b0;
         req_ch.number <= '0;
      end else begin
         if (req_ch.valid && req_ch.ready) predict_digits(req_ch.number);
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_numbers.size() > 0 && $urandom_range(99) >= req_idle_pct) begin
               req_ch.valid  <= 1'b1;
               req_ch.number <= pending_numbers.pop_front();
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // monitor: compare each digit with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_digits.size() == 0) begin
            $display("%0t: digit with nothing expected: expected none, actual char %0d last %0b",
                     $time, rsp_ch.digit_char, rsp_ch.last);
            error_count++;
         end else begin
            if (rsp_ch.digit_char !== expected_digits[0].digit_char) begin
               $display("%0t: digit_char mismatch: expected %0d, actual %0d",
                        $time, expected_digits[0].digit_char, rsp_ch.digit_char);
               error_count++;
            end
            if (rsp_ch.last !== expected_digits[0].last) begin
               $display("%0t: last mismatch: expected %0b, actual %0b",
                        $time, expected_digits[0].last, rsp_ch.last);
               error_count++;
            end
            void'(expected_digits.pop_front());
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d digits outstanding", $time, expected_digits.size());
         $display("FAIL");
         $finish;
      end
   end

   // stimulus: directed numbers, then random ones across the idling phases
   initial begin
      int          n_digits;
      logic [63:0] lo;
      logic [63:0] hi;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < 4; phase++) begin
         @(negedge clock);
         case (phase)
            0: begin
               req_idle_pct = 0;  rsp_stall_pct = 0;
            end
            1: begin
               req_idle_pct = 52; rsp_stall_pct = 0;
            end
            2: begin
               req_idle_pct = 0;  rsp_stall_pct = 52;
            end
            default: begin
               req_idle_pct = 22; rsp_stall_pct = 22;
            end
         endcase
         if (phase == 0) begin
            foreach (DIRECTED_NUMBERS[i]) pending_numbers.push_back(DIRECTED_NUMBERS[i]);
         end
         // mostly spread over digit counts, some full-range values for bit coverage
         repeat (RANDOM_PER_PHASE) begin
            if ($urandom_range(3) == 0) begin
               pending_numbers.push_back($urandom);
            end else begin
               n_digits = $urandom_range(1, 10);
               lo = 64'd1;
               repeat (n_digits - 1) lo = lo * 10;
               hi = lo * 10 - 1;
               if (n_digits == 1) lo = 64'd0;
               if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
               pending_numbers.push_back(NUMBER_W'(lo + ({32'd0, $urandom} % (hi - lo + 1))));
            end
         end
         // sender holds off until the block has delivered everything
         while (pending_numbers.size() > 0 || req_ch.valid || expected_digits.size() > 0)
            @(negedge clock);
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_digits.size() > 0) begin
         $display("%0t: %0d expected digits never arrived", $time, expected_digits.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
